/* rtl/core/dle_pkg.sv */
// Shared types and codes for the double-ended list engine.
package dle_pkg;

   typedef enum logic [2:0] {
      FN_ADD_FRONT = 3'd0,
      FN_ADD_BACK  = 3'd1,
      FN_RM_FRONT  = 3'd2,
      FN_RM_BACK   = 3'd3,
      FN_CLEAR     = 3'd4,
      FN_INSERT    = 3'd5,
      FN_RM_AT     = 3'd6,
      FN_PRINT     = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_BAD_POS = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_WALK_RD,
      S_WALK,
      S_INS_N,
      S_ALLOC_RD,
      S_ALLOC_WR,
      S_LINK,
      S_UNL_LINK,
      S_UNL_FREE,
      S_PRINT_RD,
      S_PRINT
   } state_type;

   typedef struct packed {
      func_type           func;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value_res;
      logic               last;
   } rsp_type;

endpackage

/* rtl/core/dle_store.sv */
// Entry store: value, next-link and prev-link arrays with one shared registered read address.
module dle_store #(
   parameter int CAPACITY = 32,
   localparam int IW = $clog2(CAPACITY),
   localparam int LW = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic [IW-1:0]        rd_addr,
   output logic [LW-1:0]        rd_next,
   output logic [LW-1:0]        rd_prev,
   output logic signed [31:0]   rd_value,
   input  logic                 next_we,
   input  logic [IW-1:0]        next_waddr,
   input  logic [LW-1:0]        next_wdata,
   input  logic                 prev_we,
   input  logic [IW-1:0]        prev_waddr,
   input  logic [LW-1:0]        prev_wdata,
   input  logic                 value_we,
   input  logic signed [31:0]   value_wdata
);
   import dle_pkg::*;

   logic [LW-1:0]        next_mem [CAPACITY];
   logic [LW-1:0]        prev_mem [CAPACITY];
   logic signed [31:0]   value_mem [CAPACITY];
   logic [CAPACITY-1:0]  next_valid_ff;

   logic [LW-1:0]        next_q_ff;
   logic                 next_q_valid_ff;
   logic [IW-1:0]        rd_idx_ff;

   // An entry whose next link was never written since reset or clear holds
   // the in-order free chain, which is its own index plus one.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         next_valid_ff <= '0;
      end else if (next_we) begin
         next_valid_ff[next_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      if (prev_we) begin
         prev_mem[prev_waddr] <= prev_wdata;
      end
      if (value_we) begin
         value_mem[next_waddr] <= value_wdata;
      end
      next_q_ff       <= next_mem[rd_addr];
      next_q_valid_ff <= next_valid_ff[rd_addr];
      rd_idx_ff       <= rd_addr;
      rd_prev         <= prev_mem[rd_addr];
      rd_value        <= value_mem[rd_addr];
   end

   assign rd_next = next_q_valid_ff ? next_q_ff
                                    : LW'({1'b0, rd_idx_ff}) + LW'(1);

endmodule

/* rtl/core/dle_ctrl.sv */
// Command sequencer: list registers, link walking, entry allocation and result register.
module dle_ctrl #(
   parameter int CAPACITY = 32,
   localparam int IW = $clog2(CAPACITY),
   localparam int LW = $clog2(CAPACITY + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  dle_pkg::req_type     req_item,
   output logic                 rsp_strobe,
   output dle_pkg::rsp_type     rsp_item,
   output logic                 clear,
   output logic [IW-1:0]        rd_addr,
   input  logic [LW-1:0]        rd_next,
   input  logic [LW-1:0]        rd_prev,
   input  logic signed [31:0]   rd_value,
   output logic                 next_we,
   output logic [IW-1:0]        next_waddr,
   output logic [LW-1:0]        next_wdata,
   output logic                 prev_we,
   output logic [IW-1:0]        prev_waddr,
   output logic [LW-1:0]        prev_wdata,
   output logic                 value_we,
   output logic signed [31:0]   value_wdata
);
   import dle_pkg::*;

   localparam logic [LW-1:0] NIL = LW'(CAPACITY);

   state_type       state_ff, state_in;
   req_type         req_ff, req_in;
   logic [LW-1:0]   head_ff, head_in;
   logic [LW-1:0]   tail_ff, tail_in;
   logic [LW-1:0]   free_ff, free_in;
   logic [LW-1:0]   length_ff, length_in;
   logic [LW-1:0]   cur_ff, cur_in;
   logic [LW-1:0]   nb_ff, nb_in;
   logic [IW-1:0]   e_ff, e_in;
   logic [6:0]      cnt_ff, cnt_in;
   logic [6:0]      tgt_ff, tgt_in;
   logic            rsp_strobe_ff, rsp_strobe_in;
   rsp_type         rsp_ff, rsp_in;
   logic [LW-1:0]   rd_link;
   logic            is_full;
   logic            is_empty;
   logic            bad_pos;
   state_type       walk_target;

   assign is_full     = (length_ff == NIL);
   assign is_empty    = (length_ff == '0);
   assign bad_pos     = (req_item.position == 7'd0) || (req_item.position > 7'(length_ff));
   assign walk_target = (req_ff.func == FN_INSERT) ? S_INS_N : S_UNL_LINK;
   assign rd_addr     = rd_link[IW-1:0];
   assign value_wdata = req_ff.value;
   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_item    = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= NIL;
         tail_ff       <= NIL;
         free_ff       <= '0;
         length_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         free_ff       <= free_in;
         length_ff     <= length_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cur_ff <= cur_in;
      nb_ff  <= nb_in;
      e_ff   <= e_in;
      cnt_ff <= cnt_in;
      tgt_ff <= tgt_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      free_in       = free_ff;
      length_in     = length_ff;
      cur_in        = cur_ff;
      nb_in         = nb_ff;
      e_in          = e_ff;
      cnt_in        = cnt_ff;
      tgt_in        = tgt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_link       = cur_ff;
      clear         = 1'b0;
      next_we       = 1'b0;
      next_waddr    = e_ff;
      next_wdata    = nb_ff;
      prev_we       = 1'b0;
      prev_waddr    = e_ff;
      prev_wdata    = cur_ff;
      value_we      = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in           = req_item;
               rsp_in.value_res = '0;
               rsp_in.last      = 1'b1;
               rsp_in.status    = ST_OK;
               cur_in           = head_ff;
               cnt_in           = 7'd1;
               tgt_in           = 7'd1;
               unique case (req_item.func) inside
                  FN_ADD_FRONT, FN_ADD_BACK: begin
                     if (is_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else begin
                        cur_in   = (req_item.func == FN_ADD_FRONT) ? NIL : tail_ff;
                        nb_in    = (req_item.func == FN_ADD_FRONT) ? head_ff : NIL;
                        state_in = S_ALLOC_RD;
                     end
                  end
                  FN_RM_FRONT, FN_RM_BACK: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        cur_in   = (req_item.func == FN_RM_FRONT) ? head_ff : tail_ff;
                        state_in = S_WALK_RD;
                     end
                  end
                  FN_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        clear     = 1'b1;
                        head_in   = NIL;
                        tail_in   = NIL;
                        free_in   = '0;
                        length_in = '0;
                     end
                  end
                  FN_INSERT, FN_RM_AT: begin
                     tgt_in = req_item.position;
                     if (bad_pos) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_BAD_POS;
                     end else if (req_item.func == FN_INSERT && is_full) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_FULL;
                     end else begin
                        state_in = S_WALK_RD;
                     end
                  end
                  FN_PRINT: begin
                     if (is_empty) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.status = ST_EMPTY;
                     end else begin
                        state_in = S_PRINT_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK_RD: begin
            rd_link  = cur_ff;
            state_in = (cnt_ff == tgt_ff) ? walk_target : S_WALK;
         end
         S_WALK: begin
            // The read of the entry just reached is issued in the same cycle,
            // so the walk advances one link per cycle.
            rd_link = rd_next;
            cur_in  = rd_next;
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_in == tgt_ff) begin
               state_in = walk_target;
            end
         end
         S_INS_N: begin
            nb_in    = rd_next;
            state_in = S_ALLOC_RD;
         end
         S_ALLOC_RD: begin
            rd_link  = free_ff;
            e_in     = free_ff[IW-1:0];
            state_in = S_ALLOC_WR;
         end
         S_ALLOC_WR: begin
            free_in    = rd_next;
            value_we   = 1'b1;
            next_we    = 1'b1;
            next_waddr = e_ff;
            next_wdata = nb_ff;
            prev_we    = 1'b1;
            prev_waddr = e_ff;
            prev_wdata = cur_ff;
            state_in   = S_LINK;
         end
         S_LINK: begin
            if (cur_ff != NIL) begin
               next_we    = 1'b1;
               next_waddr = cur_ff[IW-1:0];
               next_wdata = LW'(e_ff);
            end else begin
               head_in = LW'(e_ff);
            end
            if (nb_ff != NIL) begin
               prev_we    = 1'b1;
               prev_waddr = nb_ff[IW-1:0];
               prev_wdata = LW'(e_ff);
            end else begin
               tail_in = LW'(e_ff);
            end
            length_in     = length_ff + LW'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_UNL_LINK: begin
            if (rd_prev != NIL) begin
               next_we    = 1'b1;
               next_waddr = rd_prev[IW-1:0];
               next_wdata = rd_next;
            end else begin
               head_in = rd_next;
            end
            if (rd_next != NIL) begin
               prev_we    = 1'b1;
               prev_waddr = rd_next[IW-1:0];
               prev_wdata = rd_prev;
            end else begin
               tail_in = rd_prev;
            end
            state_in = S_UNL_FREE;
         end
         S_UNL_FREE: begin
            next_we       = 1'b1;
            next_waddr    = cur_ff[IW-1:0];
            next_wdata    = free_ff;
            free_in       = cur_ff;
            length_in     = length_ff - LW'(1);
            rsp_strobe_in = 1'b1;
            state_in      = S_IDLE;
         end
         S_PRINT_RD: begin
            rd_link  = head_ff;
            state_in = S_PRINT;
         end
         S_PRINT: begin
            rd_link          = rd_next;
            rsp_strobe_in    = 1'b1;
            rsp_in.status    = ST_OK;
            rsp_in.value_res = rd_value;
            rsp_in.last      = (rd_next == NIL);
            if (rd_next == NIL) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

/* rtl/core/double_ended_list_engine_core.sv */
// Top level of the double-ended list engine: sequencer plus entry store.
//
//  Channel   Ports                       Direction  Beat taken when
//  command   start, busy, req_item       in         start high and busy low
//  result    rsp_strobe, rsp_item        out        rsp_strobe high (one cycle)
//
// Commands run one at a time, and each result beat appears in the cycle after the step that
// makes it. Error and clear commands finish in the accept cycle, so busy never rises.
// An add or an end removal walks no links, insert after and remove at walk to the named
// position, and print walks the whole list with one beat per element, because walks
// follow next links one store read per cycle.
// Synchronous reset empties the list at once through per-entry valid bits on the next
// links, and the receiver cannot stall, so every beat is delivered in the cycle it appears.
module double_ended_list_engine_core #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  dle_pkg::req_type   req_item,
   output logic               rsp_strobe,
   output dle_pkg::rsp_type   rsp_item
);
   import dle_pkg::*;

   localparam int IW = $clog2(CAPACITY);
   localparam int LW = $clog2(CAPACITY + 1);

   // Store interface between the sequencer and the entry arrays.
   logic                clear;
   logic [IW-1:0]       rd_addr;
   logic [LW-1:0]       rd_next;
   logic [LW-1:0]       rd_prev;
   logic signed [31:0]  rd_value;
   logic                next_we;
   logic [IW-1:0]       next_waddr;
   logic [LW-1:0]       next_wdata;
   logic                prev_we;
   logic [IW-1:0]       prev_waddr;
   logic [LW-1:0]       prev_wdata;
   logic                value_we;
   logic signed [31:0]  value_wdata;

   // The sequencer owns head, tail, free head and length, and the
   // registered result.
   dle_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_item    (req_item),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item),
      .clear       (clear),
      .rd_addr     (rd_addr),
      .rd_next     (rd_next),
      .rd_prev     (rd_prev),
      .rd_value    (rd_value),
      .next_we     (next_we),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .prev_we     (prev_we),
      .prev_waddr  (prev_waddr),
      .prev_wdata  (prev_wdata),
      .value_we    (value_we),
      .value_wdata (value_wdata)
   );

   // The store holds the entry values and both link arrays.
   dle_store #(
      .CAPACITY (CAPACITY)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .rd_addr     (rd_addr),
      .rd_next     (rd_next),
      .rd_prev     (rd_prev),
      .rd_value    (rd_value),
      .next_we     (next_we),
      .next_waddr  (next_waddr),
      .next_wdata  (next_wdata),
      .prev_we     (prev_we),
      .prev_waddr  (prev_waddr),
      .prev_wdata  (prev_wdata),
      .value_we    (value_we),
      .value_wdata (value_wdata)
   );

endmodule

/* bench/tb.sv */
// Self-checking testbench for the double-ended list engine core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import dle_pkg::*;

   localparam int LIST_CAP = 32;
   localparam int RANDOM_CMDS = 95;
   localparam int SETTLE_CYCLES = 40;

   // A queued command, plus a flag that makes the sender hold it back until
   // the engine has delivered every result that is still owed.
   typedef struct packed {
      req_type cmd;
      logic    drain_first;
   } queued_cmd_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_item = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_item;

   double_ended_list_engine_core #(
      .CAPACITY(LIST_CAP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_strobe(rsp_strobe),
      .rsp_item  (rsp_item)
   );

   always #6 clock = ~clock;

   // Hold reset from the start, then release it on a falling edge.
   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Commands waiting to be sent, results still owed, and the list contents
   // as the engine should hold them, head first.
   queued_cmd_type          cmd_backlog[$];
   rsp_type                 owed_rsp[$];
   logic signed [31:0]      list_vals[$];

   int   mismatch_count = 0;
   int   cmds_accepted = 0;
   int   beats_checked = 0;
   int   peak_len = 0;
   int   full_refusals = 0;
   int   gen_len = 0;
   logic cmd_taken = 1'b0;

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   function automatic void owe_rsp(input status_type st, input logic signed [31:0] v,
                                   input logic fin);
      rsp_type r;
      r.status    = st;
      r.value_res = v;
      r.last      = fin;
      owed_rsp.push_back(r);
   endfunction

   // Applies one accepted command to the list contents and queues the result
   // beats it must produce. Entry indexes inside the engine are invisible from
   // the ports, so an ordered queue of values is all the state that matters.
   function automatic void list_apply(input req_type cmd);
      status_type st;
      int         len;
      int         pos;
      st  = ST_OK;
      len = list_vals.size();
      pos = int'(cmd.position);
      case (cmd.func)
         FN_ADD_FRONT: begin
            if (len >= LIST_CAP) st = ST_FULL;
            else list_vals.push_front(cmd.value);
         end
         FN_ADD_BACK: begin
            if (len >= LIST_CAP) st = ST_FULL;
            else list_vals.push_back(cmd.value);
         end
         FN_RM_FRONT: begin
            if (len == 0) st = ST_EMPTY;
            else void'(list_vals.pop_front());
         end
         FN_RM_BACK: begin
            if (len == 0) st = ST_EMPTY;
            else void'(list_vals.pop_back());
         end
         FN_CLEAR: begin
            if (len == 0) st = ST_EMPTY;
            else list_vals.delete();
         end
         FN_INSERT: begin
            // The position is judged before fullness.
            if (pos == 0 || pos > len) st = ST_BAD_POS;
            else if (len >= LIST_CAP) st = ST_FULL;
            else list_vals.insert(pos, cmd.value);
         end
         FN_RM_AT: begin
            if (pos == 0 || pos > len) st = ST_BAD_POS;
            else list_vals.delete(pos - 1);
         end
         default: begin
            if (len == 0) begin
               st = ST_EMPTY;
            end else begin
               for (int i = 0; i < len; i++)
                  owe_rsp(ST_OK, list_vals[i], i == len - 1);
               return;
            end
         end
      endcase
      if (st == ST_FULL) full_refusals++;
      if (list_vals.size() > peak_len) peak_len = list_vals.size();
      owe_rsp(st, '0, 1'b1);
   endfunction

   // Queues a command for the sender and keeps a running count of the list
   // length so that the generator can aim positions at valid entries.
   function automatic void queue_cmd(input func_type f, input logic signed [31:0] v,
                                     input logic [6:0] pos, input logic hold);
      queued_cmd_type q;
      q.cmd.func     = f;
      q.cmd.value    = v;
      q.cmd.position = pos;
      q.drain_first  = hold;
      cmd_backlog.push_back(q);
      case (f) inside
         FN_ADD_FRONT, FN_ADD_BACK: if (gen_len < LIST_CAP) gen_len++;
         FN_RM_FRONT, FN_RM_BACK:   if (gen_len > 0) gen_len--;
         FN_CLEAR:                  gen_len = 0;
         FN_INSERT: if (pos != 0 && pos <= gen_len && gen_len < LIST_CAP) gen_len++;
         FN_RM_AT:  if (pos != 0 && pos <= gen_len) gen_len--;
         default: ;
      endcase
   endfunction

   // Mostly random words, with the corners of the signed range mixed in.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   // A position that names an existing entry, or a small out-of-range one when
   // the list is empty.
   function automatic logic [6:0] pick_position();
      if (gen_len == 0) return 7'($urandom_range(1, 3));
      return 7'($urandom_range(1, gen_len));
   endfunction

   // Fill the command backlog: a short directed sweep of the corner cases,
   // then random traffic that alternates between growing and shrinking.
   initial begin
      logic grow;
      int   pick;

      // An empty list refuses every removal, clear and print, and has no
      // valid position at all.
      queue_cmd(FN_PRINT,     '0, 7'd0, 1'b0);
      queue_cmd(FN_RM_FRONT,  '0, 7'd0, 1'b0);
      queue_cmd(FN_RM_BACK,   '0, 7'd0, 1'b0);
      queue_cmd(FN_CLEAR,     '0, 7'd0, 1'b0);
      queue_cmd(FN_INSERT,    pick_value(), 7'd1, 1'b0);
      queue_cmd(FN_RM_AT,     '0, 7'd0, 1'b0);
      // Extremes of the value field at both ends.
      queue_cmd(FN_ADD_FRONT, 32'sh7FFF_FFFF, 7'd0, 1'b0);
      queue_cmd(FN_ADD_BACK,  32'sh8000_0000, 7'd127, 1'b0);
      queue_cmd(FN_ADD_FRONT, -32'sd1, 7'd0, 1'b0);
      queue_cmd(FN_ADD_BACK,  '0, 7'd0, 1'b0);
      // Insert at position zero, after the tail, in the middle, far past the end.
      queue_cmd(FN_INSERT,    pick_value(), 7'd0, 1'b0);
      queue_cmd(FN_INSERT,    32'sd12345, 7'd4, 1'b0);
      queue_cmd(FN_INSERT,    pick_value(), 7'd2, 1'b0);
      queue_cmd(FN_INSERT,    pick_value(), 7'd127, 1'b0);
      queue_cmd(FN_PRINT,     '0, 7'd0, 1'b0);
      // Remove the tail and head by position, then one past the end, then one in the middle.
      queue_cmd(FN_RM_AT,     '0, 7'd6, 1'b0);
      queue_cmd(FN_RM_AT,     '0, 7'd1, 1'b0);
      queue_cmd(FN_RM_AT,     '0, 7'd5, 1'b0);
      queue_cmd(FN_RM_AT,     '0, 7'd2, 1'b0);
      queue_cmd(FN_RM_FRONT,  '0, 7'd0, 1'b0);
      queue_cmd(FN_RM_BACK,   '0, 7'd0, 1'b0);
      queue_cmd(FN_PRINT,     '0, 7'd0, 1'b0);
      queue_cmd(FN_ADD_BACK,  pick_value(), 7'd0, 1'b0);
      // The sender waits for the engine to drain before this clear.
      queue_cmd(FN_CLEAR,     '0, 7'd0, 1'b1);
      queue_cmd(FN_PRINT,     '0, 7'd0, 1'b0);

      // Random traffic. While growing, adds dominate until the list is full
      // and a few adds are refused; then removals drain it again. A slice of
      // the traffic is noise with any command and any position.
      grow = 1'b1;
      for (int n = 0; n < RANDOM_CMDS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            queue_cmd(func_type'($urandom_range(0, 7)), pick_value(),
                      7'($urandom_range(0, 127)), n % 40 == 39);
         end else if (pick < 10) begin
            queue_cmd(FN_CLEAR, '0, 7'd0, n % 40 == 39);
         end else if (pick < 20) begin
            queue_cmd(FN_PRINT, '0, 7'($urandom), n % 40 == 39);
         end else if (pick < (grow ? 75 : 32)) begin
            queue_cmd($urandom_range(0, 1) ? FN_ADD_FRONT : FN_ADD_BACK, pick_value(),
                      7'($urandom), n % 40 == 39);
         end else if (pick < (grow ? 88 : 42)) begin
            queue_cmd(FN_INSERT, pick_value(), pick_position(), n % 40 == 39);
         end else begin
            case ($urandom_range(0, 2))
               0:       queue_cmd(FN_RM_FRONT, pick_value(), 7'($urandom), n % 40 == 39);
               1:       queue_cmd(FN_RM_BACK, pick_value(), 7'($urandom), n % 40 == 39);
               default: queue_cmd(FN_RM_AT, pick_value(), pick_position(), n % 40 == 39);
            endcase
         end
         if (grow && gen_len == LIST_CAP && $urandom_range(0, 3) == 0) grow = 1'b0;
         else if (!grow && gen_len == 0 && $urandom_range(0, 1) == 0) grow = 1'b1;
      end

      // Wait for every command to go out and every owed beat to come back,
      // then give the engine time to show any stray beat.
      while (cmd_backlog.size() != 0 || start || owed_rsp.size() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Summary: %0d commands accepted, %0d result beats checked.",
               cmds_accepted, beats_checked);
      $display("Summary: list peaked at %0d of %0d entries, %0d adds refused as full.",
               peak_len, LIST_CAP, full_refusals);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Sender. On each falling edge it retires a command that the last rising
   // edge took, then decides whether to present the next one. It works in
   // bursts of random length separated by random gaps, with some bursts run
   // back to back. Start is written once per edge so that a command kept on
   // the bus for the next beat never drops for a step.
   int burst_left = 0;
   int gap_left = 0;

   always @(negedge clock) begin
      queued_cmd_type nxt;
      logic           start_next;
      if (!reset) begin
         start_next = start;
         if (start && cmd_taken) start_next = 1'b0;
         if (!start_next) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (cmd_backlog.size() != 0 &&
                         !(cmd_backlog[0].drain_first && (owed_rsp.size() != 0 || busy))) begin
               nxt = cmd_backlog.pop_front();
               req_item <= nxt.cmd;
               start_next = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 10);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
         start <= start_next;
      end
   end

   // Monitor. On each rising edge it first checks any result beat against
   // the oldest owed one, then, when a command is taken, works out the beats
   // that command owes. Checking first keeps the final beat of one command
   // ahead of the next command when both fall on the same edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cmd_taken <= 1'b0;
      end else begin
         if (rsp_strobe) begin
            if (owed_rsp.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat status %0d value %0d last %0b",
                                       rsp_item.status, rsp_item.value_res, rsp_item.last));
            end else begin
               want = owed_rsp.pop_front();
               beats_checked++;
               if (rsp_item.status !== want.status)
                  flag_mismatch($sformatf("status %0d, expected %s",
                                          rsp_item.status, want.status.name()));
               if (rsp_item.value_res !== want.value_res)
                  flag_mismatch($sformatf("value_res %0d, expected %0d",
                                          rsp_item.value_res, want.value_res));
               if (rsp_item.last !== want.last)
                  flag_mismatch($sformatf("last %0b, expected %0b",
                                          rsp_item.last, want.last));
            end
         end
         if (start && !busy) begin
            list_apply(req_item);
            cmds_accepted++;
         end
         cmd_taken <= start && !busy;
      end
   end

   // A generous ceiling on the whole run; the slowest legal run needs a small
   // fraction of it.
   initial begin
      #2_000_000;
      $display("Timeout with %0d result beats still owed", owed_rsp.size());
      $display("Some tests failed");
      $finish;
   end

endmodule
